// ----- src/ckb_pkg.sv -----
// color key rectangle blitter: shared types, register indexes, mode codes
// and the rectangle size helper used by the csr block and the address generator.
// no dependencies.
package ckb_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PIXEL_BYTES   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_ADDRESS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_WIDTH    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_HEIGHT   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLIT_MODE     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_VALUE     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILL_COLOR    = 3'd7;

   localparam logic [2:0] MODE_COPY       = 3'd0;
   localparam logic [2:0] MODE_MONO       = 3'd1;
   localparam logic [2:0] MODE_KEY        = 3'd2;
   localparam logic [2:0] MODE_SKIP_BLACK = 3'd3;
   localparam logic [2:0] MODE_FILL       = 3'd4;

   localparam logic [11:0] RECT_LIMIT = 12'd2048;

   typedef struct packed {
      logic [11:0] screen_width;
      logic [2:0]  pixel_bytes;
      logic [23:0] start_address;
      logic [11:0] rect_width;
      logic [11:0] rect_height;
      logic [2:0]  blit_mode;
      logic [7:0]  key_value;
      logic [23:0] fill_color;
   } ckb_cfg_type;

   // rectangle size clamped to 1..2048, minus one
   function automatic logic [10:0] size_m1(input logic [11:0] size);
      logic [11:0] clamped;
      begin
         if (size == 12'd0) begin
            clamped = 12'd1;
         end else if (size > RECT_LIMIT) begin
            clamped = RECT_LIMIT;
         end else begin
            clamped = size;
         end
         size_m1 = 11'(clamped - 12'd1);
      end
   endfunction

endpackage

// ----- src/ckb_req_if.sv -----
// source pixel channel: valid/ready handshake with three source bytes.
// no dependencies.
interface ckb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte0;
   logic [7:0] src_byte1;
   logic [7:0] src_byte2;

   modport source (output valid, output src_byte0, output src_byte1, output src_byte2,
                   input ready);
   modport sink   (input valid, input src_byte0, input src_byte1, input src_byte2,
                   output ready);
endinterface

// ----- src/ckb_rsp_if.sv -----
// framebuffer write channel: valid/ready handshake with address, bytes and flags.
// no dependencies.
interface ckb_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] byte_address;
   logic [7:0]  data0;
   logic [7:0]  data1;
   logic [7:0]  data2;
   logic        write_enable;
   logic        last_pixel;

   modport source (output valid, output byte_address, output data0, output data1,
                   output data2, output write_enable, output last_pixel, input ready);
   modport sink   (input valid, input byte_address, input data0, input data1,
                   input data2, input write_enable, input last_pixel, output ready);
endinterface

// ----- src/ckb_csr_if.sv -----
// register write channel: valid/ready handshake with register index and data.
// depends on ckb_pkg for the field widths.
interface ckb_csr_if
   import ckb_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/ckb_csr.sv -----
// configuration register file of the blitter; flags a start address write.
// depends on ckb_pkg.
module ckb_csr
   import ckb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output ckb_cfg_type               cfg,
   output logic                      start_load
);

   ckb_cfg_type cfg_ff;
   ckb_cfg_type cfg_in;

   always_comb begin
      cfg_in     = cfg_ff;
      start_load = 1'b0;
      if (wr_en) begin
         case (wr_index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width = wr_data[11:0];
            REG_PIXEL_BYTES:   cfg_in.pixel_bytes = wr_data[2:0];
            REG_START_ADDRESS: begin
               cfg_in.start_address = wr_data[23:0];
               start_load           = 1'b1;
            end
            REG_RECT_WIDTH:    cfg_in.rect_width = wr_data[11:0];
            REG_RECT_HEIGHT:   cfg_in.rect_height = wr_data[11:0];
            REG_BLIT_MODE:     cfg_in.blit_mode = wr_data[2:0];
            REG_KEY_VALUE:     cfg_in.key_value = wr_data[7:0];
            REG_FILL_COLOR:    cfg_in.fill_color = wr_data[23:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= 12'd640;
         cfg_ff.pixel_bytes   <= 3'd3;
         cfg_ff.start_address <= 24'd0;
         cfg_ff.rect_width    <= 12'd1;
         cfg_ff.rect_height   <= 12'd1;
         cfg_ff.blit_mode     <= MODE_COPY;
         cfg_ff.key_value     <= 8'd0;
         cfg_ff.fill_color    <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/ckb_addr_gen.sv -----
// destination address walker: column/row counters and the running byte pointer.
// depends on ckb_pkg.
module ckb_addr_gen
   import ckb_pkg::*;
#(
   parameter int MAX_SCREEN_WIDTH = 2048,
   parameter int ADDRESS_BITS     = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ckb_cfg_type              cfg,
   input  logic                     start_load,
   input  logic [CSR_DATA_BITS-1:0] load_address,
   input  logic                     advance,
   output logic [23:0]              pixel_address,
   output logic                     last_pixel
);

   localparam int SW_LIMIT = (MAX_SCREEN_WIDTH > 4095) ? 4095 : MAX_SCREEN_WIDTH;
   localparam int STEP_BITS = 15;

   logic [ADDRESS_BITS-1:0] pointer_ff, pointer_in;
   logic [10:0]             column_ff, column_in;
   logic [10:0]             row_ff, row_in;

   logic [10:0]                 width_m1;
   logic [10:0]                 height_m1;
   logic [11:0]                 sw_eff;
   logic                        wide_pixel;
   logic                        end_col;
   logic                        end_row;
   logic signed [12:0]          row_diff;
   logic signed [STEP_BITS-1:0] row_step;
   logic [ADDRESS_BITS-1:0]     start_ptr;

   assign width_m1   = size_m1(cfg.rect_width);
   assign height_m1  = size_m1(cfg.rect_height);
   assign sw_eff     = (cfg.screen_width > 12'(SW_LIMIT)) ? 12'(SW_LIMIT) : cfg.screen_width;
   assign wide_pixel = cfg.pixel_bytes[2];
   assign end_col    = column_ff >= width_m1;
   assign end_row    = row_ff >= height_m1;
   assign start_ptr  = ADDRESS_BITS'(cfg.start_address);

   // row jump: (stride - covered columns) * bytes per pixel, may be negative
   assign row_diff = $signed({1'b0, sw_eff}) - $signed({2'b00, width_m1});
   always_comb begin
      if (wide_pixel) begin
         row_step = STEP_BITS'(row_diff) <<< 2;
      end else begin
         row_step = STEP_BITS'(row_diff) + (STEP_BITS'(row_diff) <<< 1);
      end
   end

   always_comb begin
      pointer_in = pointer_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      if (start_load) begin
         // the register file takes the new start address at this same edge
         pointer_in = ADDRESS_BITS'(load_address);
         column_in  = 11'd0;
         row_in     = 11'd0;
      end else if (advance) begin
         if (!end_col) begin
            pointer_in = pointer_ff + (wide_pixel ? ADDRESS_BITS'(4) : ADDRESS_BITS'(3));
            column_in  = column_ff + 11'd1;
         end else if (!end_row) begin
            pointer_in = pointer_ff
                       + {{(ADDRESS_BITS-STEP_BITS){row_step[STEP_BITS-1]}}, row_step};
            column_in  = 11'd0;
            row_in     = row_ff + 11'd1;
         end else begin
            pointer_in = start_ptr;
            column_in  = 11'd0;
            row_in     = 11'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         column_ff  <= 11'd0;
         row_ff     <= 11'd0;
      end else begin
         pointer_ff <= pointer_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
      end
   end

   assign pixel_address = 24'(pointer_ff);
   assign last_pixel    = end_col && end_row;

endmodule

// ----- src/ckb_pixel_unit.sv -----
// per-pixel mode logic: copy, mono expand, color key, black skip and fill.
// depends on ckb_pkg.
module ckb_pixel_unit
   import ckb_pkg::*;
(
   input  ckb_cfg_type cfg,
   input  logic [7:0]  src_byte0,
   input  logic [7:0]  src_byte1,
   input  logic [7:0]  src_byte2,
   output logic [7:0]  data0,
   output logic [7:0]  data1,
   output logic [7:0]  data2,
   output logic        write_enable
);

   logic [7:0] d0, d1, d2;
   logic       we;

   always_comb begin
      d0 = src_byte0;
      d1 = src_byte1;
      d2 = src_byte2;
      we = 1'b1;
      case (cfg.blit_mode)
         MODE_MONO: begin
            d1 = src_byte0;
            d2 = src_byte0;
         end
         MODE_KEY:        we = (src_byte0 != cfg.key_value);
         MODE_SKIP_BLACK: we = ((src_byte0 | src_byte1 | src_byte2) != 8'd0);
         MODE_FILL: begin
            d0 = cfg.fill_color[7:0];
            d1 = cfg.fill_color[15:8];
            d2 = cfg.fill_color[23:16];
         end
         default: we = 1'b1;
      endcase
   end

   // skipped pixels carry zero data
   assign data0        = we ? d0 : 8'd0;
   assign data1        = we ? d1 : 8'd0;
   assign data2        = we ? d2 : 8'd0;
   assign write_enable = we;

endmodule

// ----- src/color_key_rect_blitter_core.sv -----
// Color key rectangle blitter: takes one source pixel per clock in raster order while the
// write channel is not stalled and returns one framebuffer write (address, three bytes,
// write enable, last flag) per pixel. Each pixel passes the s1 stage register and then
// the response register. The destination address steps by the pixel size each transfer
// and jumps to the next screen row at the end of each rectangle row; after the last pixel
// it wraps to start_address. Writing start_address restarts the rectangle.
// Depends on ckb_pkg, the channel interfaces, ckb_csr, ckb_addr_gen, ckb_pixel_unit.
module color_key_rect_blitter_core
   import ckb_pkg::*;
#(
   parameter int MAX_SCREEN_WIDTH = 2048,
   parameter int ADDRESS_BITS     = 24
) (
   input  logic      clock,
   input  logic      reset,
   ckb_req_if.sink   req_chan,
   ckb_rsp_if.source rsp_chan,
   ckb_csr_if.sink   csr_chan
);

   ckb_cfg_type cfg;
   logic        start_load;
   logic        req_xfer;
   logic        s1_ready;
   logic        s2_ready;
   logic        s1_move;
   logic [23:0] cur_address;
   logic        cur_last;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte0_ff, s1_byte1_ff, s1_byte2_ff;
   logic [23:0] s1_address_ff;
   logic        s1_last_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_address_ff;
   logic [7:0]  rsp_data0_ff, rsp_data1_ff, rsp_data2_ff;
   logic        rsp_we_ff, rsp_last_ff;

   logic [7:0]  px_data0, px_data1, px_data2;
   logic        px_we;

   assign csr_chan.ready = 1'b1;

   ckb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (csr_chan.valid),
      .wr_index   (csr_chan.index),
      .wr_data    (csr_chan.data),
      .cfg        (cfg),
      .start_load (start_load)
   );

   assign s2_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;
   assign req_xfer       = req_chan.valid && s1_ready;
   assign s1_move        = s1_valid_ff && s2_ready;

   ckb_addr_gen #(
      .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH),
      .ADDRESS_BITS     (ADDRESS_BITS)
   ) u_addr_gen (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .start_load    (start_load),
      .load_address  (csr_chan.data),
      .advance       (req_xfer),
      .pixel_address (cur_address),
      .last_pixel    (cur_last)
   );

   ckb_pixel_unit u_pixel_unit (
      .cfg          (cfg),
      .src_byte0    (s1_byte0_ff),
      .src_byte1    (s1_byte1_ff),
      .src_byte2    (s1_byte2_ff),
      .data0        (px_data0),
      .data1        (px_data1),
      .data2        (px_data2),
      .write_enable (px_we)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s2_ready) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // address and last flag are taken from the walker at the request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte0_ff   <= req_chan.src_byte0;
         s1_byte1_ff   <= req_chan.src_byte1;
         s1_byte2_ff   <= req_chan.src_byte2;
         s1_address_ff <= cur_address;
         s1_last_ff    <= cur_last;
      end
      if (s1_move) begin
         rsp_address_ff <= s1_address_ff;
         rsp_data0_ff   <= px_data0;
         rsp_data1_ff   <= px_data1;
         rsp_data2_ff   <= px_data2;
         rsp_we_ff      <= px_we;
         rsp_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_address = rsp_address_ff;
   assign rsp_chan.data0        = rsp_data0_ff;
   assign rsp_chan.data1        = rsp_data1_ff;
   assign rsp_chan.data2        = rsp_data2_ff;
   assign rsp_chan.write_enable = rsp_we_ff;
   assign rsp_chan.last_pixel   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted pixel lost before the pixel stage");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("pixel stage result did not reach the response register");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_we_ff) |->
         (rsp_data0_ff == 8'd0 && rsp_data1_ff == 8'd0 && rsp_data2_ff == 8'd0))
      else $error("skipped pixel carries nonzero data");
`endif

endmodule
